// File: rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing.
package ple_pkg;

    // Default sizes of the element store.
    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the request and result fields.
    localparam int POS_W  = 9;
    localparam int WORD_W = 32;

    typedef logic [POS_W-1:0]         t_pos;
    typedef logic signed [WORD_W-1:0] t_word;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_READ   = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_FIND   = 2'd3
    } t_req;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE_RD,
        S_MOVE,
        S_MOVE_LAST,
        S_PLACE,
        S_READ_RD,
        S_READ,
        S_FIND_RD,
        S_FIND
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;       // latch the request word
        logic    idx_init;   // set the scan index for the request
        logic    rd_en;      // read the store at the scan index
        logic    step;       // advance the scan index, remember the read's target
        logic    mv_wr;      // write the last read entry to its new place
        logic    place_wr;   // write the inserted value at its position
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res;        // present a result word next cycle
        t_status res_status;
        logic    res_data;   // result carries the read entry
        logic    res_found;  // result carries the index of the read entry
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_req req;
        logic ins_bad;     // insert position beyond the count
        logic full;
        logic rw_bad;      // read or delete position at or beyond the count
        logic pos_eq_cnt;  // insert at the tail, nothing to move
        logic pos_last;    // delete of the tail, nothing to move
        logic cnt_zero;
        logic last_src;    // the scan index is the final entry to move
        logic match;       // the read entry equals the searched value
        logic scan_end;    // every entry has been read
    } t_stat;

endpackage

// File: rtl/ple_ctrl.sv
// Controller state machine of the positional list engine.
// Sequences shifts, reads and scans through command words to the datapath.
// Depends on ple_pkg.
module ple_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  ple_pkg::t_stat i_stat,
    output ple_pkg::t_cmd  o_cmd,
    output logic           busy
);

    ple_pkg::t_state r_state;
    ple_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ple_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ple_pkg::S_IDLE: begin
                if (start) begin
                    n_state = ple_pkg::S_DECODE;
                end
            end
            ple_pkg::S_DECODE: begin
                case (i_stat.req)
                    ple_pkg::REQ_INSERT: begin
                        if (i_stat.ins_bad || i_stat.full) begin
                            n_state = ple_pkg::S_IDLE;
                        end else if (i_stat.pos_eq_cnt) begin
                            n_state = ple_pkg::S_PLACE;
                        end else begin
                            n_state = ple_pkg::S_MOVE_RD;
                        end
                    end
                    ple_pkg::REQ_READ: begin
                        n_state = i_stat.rw_bad ? ple_pkg::S_IDLE : ple_pkg::S_READ_RD;
                    end
                    ple_pkg::REQ_DELETE: begin
                        if (i_stat.rw_bad || i_stat.pos_last) begin
                            n_state = ple_pkg::S_IDLE;
                        end else begin
                            n_state = ple_pkg::S_MOVE_RD;
                        end
                    end
                    ple_pkg::REQ_FIND: begin
                        n_state = i_stat.cnt_zero ? ple_pkg::S_IDLE : ple_pkg::S_FIND_RD;
                    end
                    default: n_state = ple_pkg::S_IDLE;
                endcase
            end
            ple_pkg::S_MOVE_RD, ple_pkg::S_MOVE: begin
                n_state = i_stat.last_src ? ple_pkg::S_MOVE_LAST : ple_pkg::S_MOVE;
            end
            ple_pkg::S_MOVE_LAST: begin
                if (i_stat.req == ple_pkg::REQ_INSERT) begin
                    n_state = ple_pkg::S_PLACE;
                end else begin
                    n_state = ple_pkg::S_IDLE;
                end
            end
            ple_pkg::S_PLACE:   n_state = ple_pkg::S_IDLE;
            ple_pkg::S_READ_RD: n_state = ple_pkg::S_READ;
            ple_pkg::S_READ:    n_state = ple_pkg::S_IDLE;
            ple_pkg::S_FIND_RD: n_state = ple_pkg::S_FIND;
            ple_pkg::S_FIND: begin
                if (i_stat.match || i_stat.scan_end) begin
                    n_state = ple_pkg::S_IDLE;
                end
            end
            default: n_state = ple_pkg::S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = ple_pkg::ST_OK;
        busy             = 1'b1;
        case (r_state)
            ple_pkg::S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ple_pkg::S_DECODE: begin
                case (i_stat.req)
                    ple_pkg::REQ_INSERT: begin
                        if (i_stat.ins_bad) begin
                            o_cmd.res        = 1'b1;
                            o_cmd.res_status = ple_pkg::ST_BAD_POS;
                        end else if (i_stat.full) begin
                            o_cmd.res        = 1'b1;
                            o_cmd.res_status = ple_pkg::ST_FULL;
                        end else if (!i_stat.pos_eq_cnt) begin
                            o_cmd.idx_init = 1'b1;
                        end
                    end
                    ple_pkg::REQ_READ: begin
                        if (i_stat.rw_bad) begin
                            o_cmd.res        = 1'b1;
                            o_cmd.res_status = ple_pkg::ST_BAD_POS;
                        end else begin
                            o_cmd.idx_init = 1'b1;
                        end
                    end
                    ple_pkg::REQ_DELETE: begin
                        if (i_stat.rw_bad) begin
                            o_cmd.res        = 1'b1;
                            o_cmd.res_status = ple_pkg::ST_BAD_POS;
                        end else if (i_stat.pos_last) begin
                            o_cmd.cnt_dec = 1'b1;
                            o_cmd.res     = 1'b1;
                        end else begin
                            o_cmd.idx_init = 1'b1;
                        end
                    end
                    ple_pkg::REQ_FIND: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.res        = 1'b1;
                            o_cmd.res_status = ple_pkg::ST_NOT_FOUND;
                        end else begin
                            o_cmd.idx_init = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ple_pkg::S_MOVE_RD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.step  = 1'b1;
            end
            ple_pkg::S_MOVE: begin
                o_cmd.mv_wr = 1'b1;
                o_cmd.rd_en = 1'b1;
                o_cmd.step  = 1'b1;
            end
            ple_pkg::S_MOVE_LAST: begin
                o_cmd.mv_wr = 1'b1;
                if (i_stat.req == ple_pkg::REQ_DELETE) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.res     = 1'b1;
                end
            end
            ple_pkg::S_PLACE: begin
                o_cmd.place_wr = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                o_cmd.res      = 1'b1;
            end
            ple_pkg::S_READ_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            ple_pkg::S_READ: begin
                o_cmd.res      = 1'b1;
                o_cmd.res_data = 1'b1;
            end
            ple_pkg::S_FIND_RD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.step  = 1'b1;
            end
            ple_pkg::S_FIND: begin
                if (i_stat.match) begin
                    o_cmd.res       = 1'b1;
                    o_cmd.res_found = 1'b1;
                end else if (i_stat.scan_end) begin
                    o_cmd.res        = 1'b1;
                    o_cmd.res_status = ple_pkg::ST_NOT_FOUND;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.step  = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/ple_dp.sv
// Datapath of the positional list engine: element store, count, scan index
// and result registers, driven by command words from the controller.
// Depends on ple_pkg.
module ple_dp #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [1:0]                i_req_type,
    input  logic [ple_pkg::POS_W-1:0] i_position,
    input  logic signed [31:0]        i_value,
    input  ple_pkg::t_cmd             i_cmd,
    output ple_pkg::t_stat            o_stat,
    output logic                      o_valid,
    output logic signed [31:0]        o_read_data,
    output logic signed [8:0]         o_found_index,
    output logic [1:0]                o_status,
    output logic [8:0]                o_element_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    // Element store, one write and one registered read a cycle.
    logic [DATA_WIDTH-1:0] mem [DEPTH];

    ple_pkg::t_req         r_req;
    ple_pkg::t_pos         r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         n_cnt;
    logic [CW-1:0]         r_idx;
    logic [AW-1:0]         r_wa;
    logic [DATA_WIDTH-1:0] r_rd;

    logic                  r_valid;
    ple_pkg::t_word        r_data;
    ple_pkg::t_pos         r_found;
    ple_pkg::t_status      r_status;
    ple_pkg::t_pos         r_count;

    logic [CMPW-1:0]       pos_x;
    logic [CMPW-1:0]       cnt_x;
    logic [CMPW-1:0]       idx_x;

    // Request word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= ple_pkg::t_req'(i_req_type);
            r_pos <= i_position;
            r_val <= DATA_WIDTH'($unsigned(i_value));
        end
    end

    // Element count.
    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Scan index and target address of the entry in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_init) begin
            case (r_req)
                ple_pkg::REQ_INSERT: r_idx <= r_cnt - CW'(1);
                ple_pkg::REQ_DELETE: r_idx <= CW'(r_pos) + CW'(1);
                ple_pkg::REQ_READ:   r_idx <= CW'(r_pos);
                default:             r_idx <= '0;
            endcase
        end else if (i_cmd.step) begin
            case (r_req)
                ple_pkg::REQ_INSERT: begin
                    r_idx <= r_idx - CW'(1);
                    r_wa  <= AW'(r_idx + CW'(1));
                end
                ple_pkg::REQ_DELETE: begin
                    r_idx <= r_idx + CW'(1);
                    r_wa  <= AW'(r_idx - CW'(1));
                end
                default: begin
                    r_idx <= r_idx + CW'(1);
                    r_wa  <= r_idx[AW-1:0];
                end
            endcase
        end
    end

    // Store write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mv_wr) begin
            mem[r_wa] <= r_rd;
        end else if (i_cmd.place_wr) begin
            mem[AW'(r_pos)] <= r_val;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[r_idx[AW-1:0]];
        end
    end

    // Status toward the controller.
    assign pos_x = CMPW'(r_pos);
    assign cnt_x = CMPW'(r_cnt);
    assign idx_x = CMPW'(r_idx);

    always_comb begin
        o_stat.req        = r_req;
        o_stat.ins_bad    = pos_x > cnt_x;
        o_stat.full       = r_cnt == CW'(DEPTH);
        o_stat.rw_bad     = pos_x >= cnt_x;
        o_stat.pos_eq_cnt = pos_x == cnt_x;
        o_stat.pos_last   = pos_x == (cnt_x - CMPW'(1));
        o_stat.cnt_zero   = r_cnt == '0;
        o_stat.match      = r_rd == r_val;
        o_stat.scan_end   = r_idx == r_cnt;
        if (r_req == ple_pkg::REQ_INSERT) begin
            o_stat.last_src = idx_x == pos_x;
        end else begin
            o_stat.last_src = r_idx == (r_cnt - CW'(1));
        end
    end

    // Result word, shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res) begin
            r_status <= i_cmd.res_status;
            r_count  <= ple_pkg::t_pos'(n_cnt);
            r_data   <= i_cmd.res_data ? ple_pkg::WORD_W'($signed(r_rd)) : '0;
            r_found  <= i_cmd.res_found ? ple_pkg::t_pos'(r_wa) : '1;
        end
    end

    assign o_valid         = r_valid;
    assign o_read_data     = r_data;
    assign o_found_index   = $signed(r_found);
    assign o_status        = r_status;
    assign o_element_count = r_count;

endmodule

// File: rtl/positional_list_engine.sv
// Positional list engine: a bounded ordered list with insert, read, delete and find.
// Throughput: one request at a time, one store entry moved or scanned per cycle; a new word is
// taken as its result shows. Reset (synchronous, active low) empties the list; o_valid strobes
// once; no receiver stall.
module positional_list_engine #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_req_type,
    input  logic [ple_pkg::POS_W-1:0] i_position,
    input  logic signed [31:0]        i_value,
    output logic                      o_valid,
    output logic signed [31:0]        o_read_data,
    output logic signed [8:0]         o_found_index,
    output logic [1:0]                o_status,
    output logic [8:0]                o_element_count
);

    ple_pkg::t_cmd  cmd;
    ple_pkg::t_stat stat;

    // Controller.
    ple_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Datapath.
    ple_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_type      (i_req_type),
        .i_position      (i_position),
        .i_value         (i_value),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_read_data     (o_read_data),
        .o_found_index   (o_found_index),
        .o_status        (o_status),
        .o_element_count (o_element_count)
    );

endmodule

// File: rtl/ple_chk.sv
// Port checker for the positional list engine, bound to the top level.
// Watches the command handshake and the result words. Depends on ple_pkg.
module ple_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [31:0] o_read_data,
    input logic signed [8:0]  o_found_index,
    input logic [1:0]         o_status
);

    // Reset leaves the engine idle with no word pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("engine not idle after reset");

    // An accepted request always occupies the engine.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // A result word appears only once the engine is free again.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word shown while busy");

    // Result words never come in adjacent cycles.
    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result words in a row");

    // Data and an index are only reported with a good status.
    a_fields_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_read_data != 0) || (o_found_index != -9'sd1)))
            |-> (o_status == ple_pkg::ST_OK))
        else $error("data or index reported with a failing status");

endmodule

bind positional_list_engine ple_chk u_ple_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_read_data   (o_read_data),
    .o_found_index (o_found_index),
    .o_status      (o_status)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_engine: insert, read, delete and find words
// go in through start/busy, and every strobed result is compared with a list model.
// Depends on ple_pkg and positional_list_engine.
module testbench;
    import ple_pkg::*;

    localparam int LIST_DEPTH    = DEPTH_DEF;
    localparam int WORD_TARGET   = 1700;
    localparam int SETTLE_CYCLES = LIST_DEPTH + 16;
    localparam int PRINT_LIMIT   = 100;

    // One request word waiting to be driven.
    typedef struct {
        t_req  req;
        t_pos  pos;
        t_word val;
        bit    wait_drain;
    } t_list_request;

    // One result word the list should produce.
    typedef struct {
        t_word             data;
        logic signed [8:0] found;
        t_status           status;
        logic [8:0]        count;
    } t_list_reply;

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      start           = 1'b0;
    logic                      busy;
    logic [1:0]                i_req_type      = 2'd0;
    logic [POS_W-1:0]          i_position      = '0;
    logic signed [31:0]        i_value         = '0;
    logic                      o_valid;
    logic signed [31:0]        o_read_data;
    logic signed [8:0]         o_found_index;
    logic [1:0]                o_status;
    logic [8:0]                o_element_count;

    t_list_request list_requests[$];
    t_list_reply   list_replies[$];
    t_word         list_model[LIST_DEPTH];
    int            model_len      = 0;
    int            plan_len       = 0;
    bit            drain_next     = 1'b0;
    bit            word_taken     = 1'b0;
    int            words_sent     = 0;
    int            words_accepted = 0;
    int            words_total    = 0;
    int            gap_left       = 0;
    int            error_count    = 0;

    positional_list_engine #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .o_read_data     (o_read_data),
        .o_found_index   (o_found_index),
        .o_status        (o_status),
        .o_element_count (o_element_count)
    );

    // Free-running clock, 10 ns period.
    always #5 i_clk = ~i_clk;

    // Print one mismatch line (up to a limit) and count it.
    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Apply one request to the list model and return the result it must give.
    function automatic t_list_reply list_apply(t_req req, t_pos pos, t_word val);
        t_list_reply res;
        int          i;
        res.data   = '0;
        res.found  = -9'sd1;
        res.status = ST_OK;
        case (req)
            REQ_INSERT: begin
                if (pos > model_len) begin
                    res.status = ST_BAD_POS;
                end else if (model_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = model_len; i > pos; i--) begin
                        list_model[i] = list_model[i-1];
                    end
                    list_model[pos] = val;
                    model_len++;
                end
            end
            REQ_READ: begin
                if (pos >= model_len) begin
                    res.status = ST_BAD_POS;
                end else begin
                    res.data = list_model[pos];
                end
            end
            REQ_DELETE: begin
                if (pos >= model_len) begin
                    res.status = ST_BAD_POS;
                end else begin
                    for (i = pos; i + 1 < model_len; i++) begin
                        list_model[i] = list_model[i+1];
                    end
                    model_len--;
                end
            end
            default: begin
                // The first matching entry wins.
                res.status = ST_NOT_FOUND;
                for (i = 0; i < model_len; i++) begin
                    if (list_model[i] == val) begin
                        res.found  = i[8:0];
                        res.status = ST_OK;
                        break;
                    end
                end
            end
        endcase
        res.count = model_len[8:0];
        return res;
    endfunction

    // Queue a request and track the list length it leads to, for position choices.
    task automatic queue_request(t_req req, int pos, t_word val);
        t_list_request item;
        item.req        = req;
        item.pos        = t_pos'(pos);
        item.val        = val;
        item.wait_drain = drain_next;
        drain_next      = 1'b0;
        list_requests.push_back(item);
        if (req == REQ_INSERT && pos <= plan_len && plan_len < LIST_DEPTH) begin
            plan_len++;
        end else if (req == REQ_DELETE && pos < plan_len) begin
            plan_len--;
        end
    endtask

    // Values lean on a small pool so that finds hit and duplicates appear.
    function automatic t_word pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            return t_word'($urandom_range(0, 15)) - 8;
        end
        if (roll < 50) begin
            case ($urandom_range(0, 3))
                0: return t_word'(32'h8000_0000);
                1: return t_word'(32'h7FFF_FFFF);
                2: return t_word'(32'h0000_0000);
                default: return t_word'(32'hFFFF_FFFF);
            endcase
        end
        return t_word'($urandom());
    endfunction

    // One random request; most positions are in range, some hit the head or tail.
    task automatic random_request(int ins_pct, int del_pct);
        int   roll;
        int   top;
        int   pos;
        t_req req;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
            req = REQ_INSERT;
        end else if (roll < ins_pct + del_pct) begin
            req = REQ_DELETE;
        end else if ($urandom_range(0, 4) < 3) begin
            req = REQ_READ;
        end else begin
            req = REQ_FIND;
        end
        top  = (req == REQ_INSERT) ? plan_len : plan_len - 1;
        roll = $urandom_range(0, 99);
        if (roll < 10 || top < 0) begin
            pos = $urandom_range(0, 511);
        end else if (roll < 20) begin
            pos = 0;
        end else if (roll < 30) begin
            pos = top;
        end else begin
            pos = $urandom_range(0, top);
        end
        queue_request(req, pos, pick_value());
    endtask

    // Driver: holds a word until it is taken, with random gaps and a drain pause before each marked request.
    always @(negedge i_clk) begin
        t_list_request item;
        bit            quiet;
        quiet = (words_sent >= 700 && words_sent < 1000);
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !word_taken) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (list_requests.size() == 0
                     || (list_requests[0].wait_drain && list_replies.size() != 0)) begin
            start <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 7) begin
            gap_left = $urandom_range(0, 11);
            start <= 1'b0;
        end else begin
            item = list_requests.pop_front();
            start      <= 1'b1;
            i_req_type <= item.req;
            i_position <= item.pos;
            i_value    <= item.val;
            words_sent++;
        end
    end

    // Monitor: checks each strobed result, then records any word taken at this edge.
    always @(posedge i_clk) begin
        t_list_reply want;
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid !== 1'b0) begin
                if (list_replies.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = list_replies.pop_front();
                    if (o_read_data !== want.data) begin
                        report_mismatch($sformatf("read_data got %0d expected %0d",
                                                  o_read_data, want.data));
                    end
                    if (o_found_index !== want.found) begin
                        report_mismatch($sformatf("found_index got %0d expected %0d",
                                                  o_found_index, want.found));
                    end
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  o_status, want.status));
                    end
                    if (o_element_count !== want.count) begin
                        report_mismatch($sformatf("element_count got %0d expected %0d",
                                                  o_element_count, want.count));
                    end
                end
            end
            if (start && !busy) begin
                word_taken = 1'b1;
                words_accepted++;
                list_replies.push_back(list_apply(t_req'(i_req_type), i_position, i_value));
            end
        end
    end

    // Stimulus: directed corner cases, then random phases, then wait for the last result.
    initial begin
        // Empty list: find misses, read and delete are out of range, insert past the end.
        queue_request(REQ_FIND, 0, 0);
        queue_request(REQ_READ, 0, 0);
        queue_request(REQ_DELETE, 0, 0);
        queue_request(REQ_INSERT, 1, 7);
        // Build min, 0, max, -1, -1 through head, middle and tail inserts.
        queue_request(REQ_INSERT, 0, t_word'(32'h7FFF_FFFF));
        queue_request(REQ_INSERT, 0, t_word'(32'h8000_0000));
        queue_request(REQ_INSERT, 2, -1);
        queue_request(REQ_INSERT, 1, 0);
        queue_request(REQ_INSERT, 511, 5);
        queue_request(REQ_INSERT, 5, 5);
        queue_request(REQ_INSERT, 4, -1);
        queue_request(REQ_READ, 0, 0);
        queue_request(REQ_READ, 4, 0);
        queue_request(REQ_READ, 5, 0);
        queue_request(REQ_READ, 511, 0);
        // Duplicates report the first position.
        queue_request(REQ_FIND, 0, -1);
        queue_request(REQ_FIND, 0, t_word'(32'h8000_0000));
        queue_request(REQ_FIND, 0, 12345);
        // Deleting the head removes exactly one element.
        queue_request(REQ_DELETE, 0, 0);
        queue_request(REQ_READ, 0, 0);
        queue_request(REQ_DELETE, 3, 0);
        queue_request(REQ_DELETE, 3, 0);
        queue_request(REQ_DELETE, 256, 0);
        queue_request(REQ_FIND, 0, t_word'(32'h7FFF_FFFF));
        queue_request(REQ_READ, 2, 0);

        // Grow until full, so that full rejections and long shifts occur.
        drain_next = 1'b1;
        repeat (400) random_request(85, 5);
        // Churn near the top.
        drain_next = 1'b1;
        repeat (300) random_request(45, 40);
        // Shrink to empty, then work around an empty list.
        while (plan_len > 0) random_request(5, 85);
        repeat (40) random_request(20, 30);
        // Mixed traffic for the rest.
        drain_next = 1'b1;
        while (list_requests.size() < WORD_TARGET) random_request(35, 30);
        words_total = list_requests.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_accepted < words_total || list_replies.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (error_count == 0 && list_replies.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/ple_pkg.sv
rtl/ple_ctrl.sv
rtl/ple_dp.sv
rtl/positional_list_engine.sv
rtl/ple_chk.sv
verif/testbench.sv
